### hdl/serial_commanded_hysteresis_thermostat_top_defines.svh
// assertion macros used by the thermostat back end
`ifndef SERIAL_COMMANDED_HYSTERESIS_THERMOSTAT_TOP_DEFINES_SVH
`define SERIAL_COMMANDED_HYSTERESIS_THERMOSTAT_TOP_DEFINES_SVH

// same-cycle implication, checked on clk, quiet in reset
`define SCHT_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scht check failed");

// next-cycle implication, checked on clk, quiet in reset
`define SCHT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scht check failed");

`endif

### hdl/scht_pkg.sv
// types and constants shared by the thermostat modules
`timescale 1ns / 1ps

package scht_pkg;

	typedef enum logic [2:0] {
		CMD_NONE = 3'd0,
		CMD_P    = 3'd1,
		CMD_H    = 3'd2,
		CMD_S    = 3'd3,
		CMD_R    = 3'd4,
		CMD_T    = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_LETTER = 2'd0,
		KIND_DOT    = 2'd1,
		KIND_CHAR   = 2'd2,
		KIND_TICK   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		cmd_t       cmd;
		logic       is_one;
		logic [7:0] rx_byte;
		logic [9:0] setpoint_sample;
		logic       run_button;
		logic       up_button;
		logic       down_button;
	} item_t;

	localparam logic [7:0] CHAR_DOT  = 8'h2E;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_ONE  = 8'h31;
	localparam logic [7:0] CHAR_P    = 8'h50;
	localparam logic [7:0] CHAR_H    = 8'h48;
	localparam logic [7:0] CHAR_S    = 8'h53;
	localparam logic [7:0] CHAR_R    = 8'h52;
	localparam logic [7:0] CHAR_T    = 8'h54;

	localparam logic [15:0] BAND_RESET = 16'd20;
	localparam logic [15:0] BAND_MAX   = 16'd202;
	localparam logic [16:0] BAND_CAP   = 17'd204;
	localparam logic [15:0] BAND_MIN   = 16'd2;
	localparam logic [15:0] BAND_STEP  = 16'd2;

	localparam int IN_W  = 24;
	localparam int OUT_W = 24;

endpackage

### hdl/serial_commanded_hysteresis_thermostat_top.sv
// top level of the serial-commanded hysteresis thermostat
`timescale 1ns / 1ps

// one request per input transfer: s_axis_tuser low carries a serial byte in
// s_axis_tdata[7:0], high carries a control tick (setpoint sample and three
// button strobes). every request yields exactly one result on m_axis.
// bytes build commands (P, H, S, R or T, digits or a flag character, then '.')
// that load the band, the measured temperature, the run flag or the heater, but P loads nothing;
// ticks run the hysteresis loop and the band buttons.
// a request taken is registered in a two-entry queue; the back end pops it
// from the queue head and registers its result in the result register.
// throughput is one request per cycle while the result register is empty or
// being read, as each pop updates the back end state and result register.
// a valid result holds while m_axis_tready is low; the back end then stops
// and the queue fills; s_axis_tready drops only once both entries are taken.
// arst_n clears the queue and result valid, selects no command, clears the
// digit buffer, temperature and drives, and sets the band to 20.
module serial_commanded_hysteresis_thermostat_top #(
	parameter int DIGITS = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// rx_byte, setpoint_sample, run_button, up_button, down_button, zero pad
	input  logic [scht_pkg::IN_W-1:0]   s_axis_tdata,
	// req_type
	input  logic                        s_axis_tuser,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// heater_on, fan_on, running, band_now, heater_report, run_report,
	// band_report, zero pad
	output logic [scht_pkg::OUT_W-1:0]  m_axis_tdata
);

	logic            q_full;
	logic            push;
	logic            pop;
	logic            head_valid;
	scht_pkg::item_t push_item;
	scht_pkg::item_t head_item;

	scht_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_full        (q_full),
		.push          (push),
		.item          (push_item)
	);

	scht_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	scht_back #(
		.DIGITS (DIGITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_item     (head_item),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

### hdl/scht_front.sv
// front end: unpacks and classifies each incoming request
`timescale 1ns / 1ps

module scht_front (
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [scht_pkg::IN_W-1:0]      s_axis_tdata,
	input  logic                           s_axis_tuser,
	input  logic                           q_full,
	output logic                           push,
	output scht_pkg::item_t                item
);

	logic [7:0] c;

	assign c             = s_axis_tdata[7:0];
	assign s_axis_tready = !q_full;
	assign push          = s_axis_tvalid && !q_full;

	always_comb begin
		item                 = '0;
		item.rx_byte         = c;
		item.setpoint_sample = s_axis_tdata[17:8];
		item.run_button      = s_axis_tdata[18];
		item.up_button       = s_axis_tdata[19];
		item.down_button     = s_axis_tdata[20];
		item.is_one          = (c == scht_pkg::CHAR_ONE);
		item.cmd             = scht_pkg::CMD_NONE;
		if (s_axis_tuser) begin
			item.kind = scht_pkg::KIND_TICK;
		end else begin
			case (c)
				scht_pkg::CHAR_P: item.cmd = scht_pkg::CMD_P;
				scht_pkg::CHAR_H: item.cmd = scht_pkg::CMD_H;
				scht_pkg::CHAR_S: item.cmd = scht_pkg::CMD_S;
				scht_pkg::CHAR_R: item.cmd = scht_pkg::CMD_R;
				scht_pkg::CHAR_T: item.cmd = scht_pkg::CMD_T;
				default:          item.cmd = scht_pkg::CMD_NONE;
			endcase
			if (item.cmd != scht_pkg::CMD_NONE) begin
				item.kind = scht_pkg::KIND_LETTER;
			end else if (c == scht_pkg::CHAR_DOT) begin
				item.kind = scht_pkg::KIND_DOT;
			end else begin
				item.kind = scht_pkg::KIND_CHAR;
			end
		end
	end

endmodule

### hdl/scht_queue.sv
// two-entry queue between front and back ends
`timescale 1ns / 1ps

module scht_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  scht_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output scht_pkg::item_t head_item
);

	scht_pkg::item_t entry_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### hdl/scht_back.sv
// back end: command parser, control loop and result register
`timescale 1ns / 1ps
`include "serial_commanded_hysteresis_thermostat_top_defines.svh"

module scht_back #(
	parameter int DIGITS = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        head_valid,
	input  scht_pkg::item_t             head_item,
	output logic                        pop,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [scht_pkg::OUT_W-1:0]  m_axis_tdata
);

	localparam int CW = $clog2(DIGITS + 1);
	localparam int IW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

	scht_pkg::cmd_t cmd_q, cmd_d;
	logic [CW-1:0]  dcount_q, dcount_d;
	logic [7:0]     dbuf_q [DIGITS];
	logic [7:0]     dbuf_d [DIGITS];
	logic           flag_q, flag_d;
	logic [15:0]    temp_q, temp_d;
	logic [15:0]    band_q, band_d;
	logic           run_q, run_d;
	logic           heater_q, heater_d;
	logic           fan_q, fan_d;
	logic           heater_rep, run_rep, band_rep;
	logic           m_tvalid_q;
	logic [scht_pkg::OUT_W-1:0] out_q;

	logic [15:0]        decoded;
	logic signed [17:0] sp_s, t_s, hi_s, lo_s;
	logic [16:0]        up_sum;
	logic [15:0]        band_up;

	assign pop           = head_valid && (!m_tvalid_q || m_axis_tready);
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = out_q;

	// weighted sum of all buffer entries, wrapping at 16 bits
	always_comb begin
		logic [15:0] acc;
		logic [15:0] d;
		acc = 16'd0;
		for (int i = 0; i < DIGITS; i++) begin
			d   = {8'd0, dbuf_q[i]} - {8'd0, scht_pkg::CHAR_ZERO};
			acc = (acc << 3) + (acc << 1) + d;
		end
		decoded = acc;
	end

	assign sp_s = $signed({8'd0, head_item.setpoint_sample});
	assign t_s  = $signed({2'd0, temp_q});
	assign hi_s = t_s + $signed({2'd0, band_q});
	assign lo_s = t_s - $signed({2'd0, band_q});

	always_comb begin
		cmd_d      = cmd_q;
		dcount_d   = dcount_q;
		dbuf_d     = dbuf_q;
		flag_d     = flag_q;
		temp_d     = temp_q;
		band_d     = band_q;
		run_d      = run_q;
		heater_d   = heater_q;
		fan_d      = fan_q;
		heater_rep = 1'b0;
		run_rep    = 1'b0;
		band_rep   = 1'b0;
		up_sum     = {1'b0, band_q} + {1'b0, scht_pkg::BAND_STEP};
		band_up    = band_q;
		case (head_item.kind)
			scht_pkg::KIND_LETTER: begin
				cmd_d    = head_item.cmd;
				dcount_d = '0;
			end
			scht_pkg::KIND_DOT: begin
				case (cmd_q)
					scht_pkg::CMD_H: band_d   = decoded;
					scht_pkg::CMD_T: temp_d   = decoded;
					scht_pkg::CMD_S: run_d    = flag_q;
					scht_pkg::CMD_R: heater_d = flag_q;
					default:         ;
				endcase
				dcount_d = '0;
			end
			scht_pkg::KIND_CHAR: begin
				case (cmd_q)
					scht_pkg::CMD_P, scht_pkg::CMD_H, scht_pkg::CMD_T: begin
						if (dcount_q < CW'(DIGITS)) begin
							dbuf_d[dcount_q[IW-1:0]] = head_item.rx_byte;
							dcount_d                 = dcount_q + CW'(1);
						end
					end
					scht_pkg::CMD_S, scht_pkg::CMD_R: flag_d = head_item.is_one;
					default:                          ;
				endcase
			end
			scht_pkg::KIND_TICK: begin
				if (run_q) begin
					if (sp_s > hi_s) begin
						heater_d   = 1'b1;
						heater_rep = 1'b1;
					end else if (sp_s < lo_s) begin
						heater_d   = 1'b0;
						heater_rep = 1'b1;
					end
					if (sp_s <= lo_s) begin
						fan_d = 1'b1;
					end else if (sp_s == t_s) begin
						fan_d = 1'b0;
					end
					if (head_item.run_button) begin
						run_d      = 1'b0;
						heater_d   = 1'b0;
						fan_d      = 1'b0;
						run_rep    = 1'b1;
						heater_rep = 1'b1;
					end
				end else if (head_item.run_button) begin
					run_d   = 1'b1;
					run_rep = 1'b1;
				end
				if (head_item.up_button) begin
					band_up  = (up_sum >= scht_pkg::BAND_CAP) ? scht_pkg::BAND_MAX
						: up_sum[15:0];
					band_rep = 1'b1;
				end
				band_d = band_up;
				if (head_item.down_button) begin
					band_d   = (band_up <= scht_pkg::BAND_MIN) ? scht_pkg::BAND_MIN
						: band_up - scht_pkg::BAND_STEP;
					band_rep = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q      <= scht_pkg::CMD_NONE;
			dcount_q   <= '0;
			for (int i = 0; i < DIGITS; i++) begin
				dbuf_q[i] <= 8'd0;
			end
			flag_q     <= 1'b0;
			temp_q     <= 16'd0;
			band_q     <= scht_pkg::BAND_RESET;
			run_q      <= 1'b0;
			heater_q   <= 1'b0;
			fan_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (pop) begin
				cmd_q    <= cmd_d;
				dcount_q <= dcount_d;
				dbuf_q   <= dbuf_d;
				flag_q   <= flag_d;
				temp_q   <= temp_d;
				band_q   <= band_d;
				run_q    <= run_d;
				heater_q <= heater_d;
				fan_q    <= fan_d;
			end
			if (pop) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// result register: heater, fan, run, band, three report flags, padding
	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= {2'b00, band_rep, run_rep, heater_rep, band_d, run_d, fan_d, heater_d};
		end
	end

	// after an up press the band lies in 2..203, so an odd band can pass the top of 202
	`SCHT_ASSERT_NEXT(a_band_after_up,
		pop && head_item.kind == scht_pkg::KIND_TICK && head_item.up_button,
		band_q >= scht_pkg::BAND_MIN && {1'b0, band_q} < scht_pkg::BAND_CAP)
	`SCHT_ASSERT_NEXT(a_stop_drives_off,
		pop && head_item.kind == scht_pkg::KIND_TICK && run_q && head_item.run_button,
		!run_q && !heater_q && !fan_q && out_q[20] && out_q[19])
	`SCHT_ASSERT_NEXT(a_byte_no_reports,
		pop && head_item.kind != scht_pkg::KIND_TICK,
		m_tvalid_q && out_q[21:19] == 3'b000)
	`SCHT_ASSERT_IMPL(a_result_matches_state,
		m_tvalid_q && !$past(pop) == 1'b0,
		out_q[0] == heater_q && out_q[1] == fan_q && out_q[2] == run_q && out_q[18:3] == band_q)

endmodule

### bench/tb_top.sv
// self-checking bench for the serial-commanded hysteresis thermostat top level
`timescale 1ns / 1ps

module tb_top;
	import scht_pkg::*;

	localparam int NUM_DIGITS   = 4;
	localparam int TOTAL_REQS   = 650;
	localparam int TAIL_REQS    = 80;
	localparam int HOLD_CYCLES  = 200;
	localparam int HOLD_AFTER   = 300;
	localparam int DRAIN_CYCLES = 10;
	localparam int MAX_PRINTS   = 40;

	typedef struct {
		logic       tick;
		logic [7:0] rx;
		logic [9:0] sp;
		logic       run_b;
		logic       up_b;
		logic       dn_b;
	} thermo_req_t;

	typedef struct {
		logic        heater;
		logic        fan;
		logic        running;
		logic [15:0] band;
		logic        heater_rep;
		logic        run_rep;
		logic        band_rep;
	} thermo_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata = '0;
	logic              s_axis_tuser = 1'b0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_W-1:0]  m_axis_tdata;

	thermo_req_t    pending_reqs[$];
	thermo_result_t expected_results[$];

	// predictor state
	cmd_t        cmd_sel;
	int          digit_cnt;
	logic [7:0]  digit_buf[NUM_DIGITS];
	logic        flag_val;
	logic [15:0] temp_reg;
	logic [15:0] band_reg;
	logic        run_r;
	logic        heat_r;
	logic        fan_r;

	int errors = 0;
	int ticks_seen = 0;
	int bytes_seen = 0;
	int commands_closed = 0;
	int band_top_hits = 0;
	int band_bottom_hits = 0;
	int results_checked = 0;

	int send_gap = 0;
	int recv_gap = 0;
	int hold_left = 0;
	bit hold_done = 0;
	bit send_calm = 0;
	bit recv_calm = 0;

	serial_commanded_hysteresis_thermostat_top #(
		.DIGITS(NUM_DIGITS)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("%0t ns %s: got %0d, want %0d", $time, what, got, want);
	endtask

	task automatic check_field(input string what, input int got, input int want);
		if (got != want)
			report_mismatch(what, got, want);
	endtask

	function automatic void clear_thermostat();
		cmd_sel = CMD_NONE;
		digit_cnt = 0;
		for (int i = 0; i < NUM_DIGITS; i++)
			digit_buf[i] = 8'h00;
		flag_val = 1'b0;
		temp_reg = 16'd0;
		band_reg = BAND_RESET;
		run_r = 1'b0;
		heat_r = 1'b0;
		fan_r = 1'b0;
	endfunction

	function automatic logic [15:0] digit_value();
		logic [15:0] acc;
		acc = 16'd0;
		for (int i = 0; i < NUM_DIGITS; i++)
			acc = acc * 16'd10 + ({8'h00, digit_buf[i]} - {8'h00, CHAR_ZERO});
		return acc;
	endfunction

	function automatic thermo_result_t thermostat_next(input thermo_req_t r);
		thermo_result_t res;
		cmd_t sel;
		logic [15:0] dv;
		int sp;
		int t;
		int h;
		int nb;
		res.heater_rep = 1'b0;
		res.run_rep = 1'b0;
		res.band_rep = 1'b0;
		if (!r.tick) begin
			bytes_seen++;
			case (r.rx)
				CHAR_P: sel = CMD_P;
				CHAR_H: sel = CMD_H;
				CHAR_S: sel = CMD_S;
				CHAR_R: sel = CMD_R;
				CHAR_T: sel = CMD_T;
				default: sel = CMD_NONE;
			endcase
			dv = digit_value();
			if (sel != CMD_NONE) begin
				cmd_sel = sel;
				digit_cnt = 0;
			end else if (r.rx == CHAR_DOT) begin
				case (cmd_sel)
					CMD_H: band_reg = dv;
					CMD_T: temp_reg = dv;
					CMD_S: run_r = flag_val;
					CMD_R: heat_r = flag_val;
					default: ;
				endcase
				if (cmd_sel != CMD_NONE)
					commands_closed++;
				digit_cnt = 0;
			end else if (cmd_sel == CMD_P || cmd_sel == CMD_H || cmd_sel == CMD_T) begin
				if (digit_cnt < NUM_DIGITS) begin
					digit_buf[digit_cnt] = r.rx;
					digit_cnt++;
				end
			end else if (cmd_sel == CMD_S || cmd_sel == CMD_R) begin
				flag_val = (r.rx == CHAR_ONE);
			end
		end else begin
			ticks_seen++;
			sp = int'(r.sp);
			t = int'(temp_reg);
			h = int'(band_reg);
			if (run_r) begin
				if (sp > t + h) begin
					heat_r = 1'b1;
					res.heater_rep = 1'b1;
				end else if (sp < t - h) begin
					heat_r = 1'b0;
					res.heater_rep = 1'b1;
				end
				if (sp <= t - h)
					fan_r = 1'b1;
				else if (sp == t)
					fan_r = 1'b0;
				if (r.run_b) begin
					run_r = 1'b0;
					heat_r = 1'b0;
					fan_r = 1'b0;
					res.run_rep = 1'b1;
					res.heater_rep = 1'b1;
				end
			end else if (r.run_b) begin
				run_r = 1'b1;
				res.run_rep = 1'b1;
			end
			if (r.up_b) begin
				nb = int'(band_reg) + int'(BAND_STEP);
				if (nb >= int'(BAND_CAP)) begin
					band_reg = BAND_MAX;
					band_top_hits++;
				end else begin
					band_reg = nb[15:0];
				end
				res.band_rep = 1'b1;
			end
			if (r.dn_b) begin
				nb = int'(band_reg) - int'(BAND_STEP);
				if (nb <= 0) begin
					band_reg = BAND_MIN;
					band_bottom_hits++;
				end else begin
					band_reg = nb[15:0];
				end
				res.band_rep = 1'b1;
			end
		end
		res.heater = heat_r;
		res.fan = fan_r;
		res.running = run_r;
		res.band = band_reg;
		return res;
	endfunction

	// stimulus generation
	task automatic push_byte(input logic [7:0] c);
		thermo_req_t r;
		r.tick = 1'b0;
		r.rx = c;
		r.sp = 10'($urandom);
		r.run_b = 1'($urandom);
		r.up_b = 1'($urandom);
		r.dn_b = 1'($urandom);
		pending_reqs.push_back(r);
	endtask

	task automatic push_tick(input int sp, input logic run_b, input logic up_b,
			input logic dn_b);
		thermo_req_t r;
		r.tick = 1'b1;
		r.rx = 8'($urandom);
		r.sp = sp[9:0];
		r.run_b = run_b;
		r.up_b = up_b;
		r.dn_b = dn_b;
		pending_reqs.push_back(r);
	endtask

	task automatic push_number(input int value, input int nd);
		int p;
		for (int i = nd - 1; i >= 0; i--) begin
			p = 1;
			for (int j = 0; j < i; j++)
				p = p * 10;
			push_byte(CHAR_ZERO + 8'((value / p) % 10));
		end
	endtask

	function automatic logic [7:0] pick_letter();
		case ($urandom_range(0, 4))
			0: return CHAR_P;
			1: return CHAR_H;
			2: return CHAR_S;
			3: return CHAR_R;
			default: return CHAR_T;
		endcase
	endfunction

	initial begin
		int temp_hint;
		int band_hint;
		int sel;
		int value;
		int nd;
		int sp;
		int off;
		// directed opening
		push_tick(0, 1'b0, 1'b0, 1'b0);
		push_byte(CHAR_ZERO + 8'd5);
		push_byte(CHAR_DOT);
		push_byte(CHAR_H);
		push_byte(CHAR_ONE);
		push_byte(CHAR_ZERO);
		push_byte(CHAR_DOT);
		push_tick(1023, 1'b0, 1'b1, 1'b0);
		push_byte(CHAR_T);
		push_number(12345, 5);
		push_byte(CHAR_DOT);
		push_byte(CHAR_S);
		push_byte(CHAR_ONE);
		push_byte(CHAR_DOT);
		push_tick(1023, 1'b0, 1'b0, 1'b0);
		push_tick(0, 1'b1, 1'b0, 1'b1);
		push_byte(CHAR_R);
		push_byte(CHAR_ONE);
		push_byte(CHAR_DOT);
		push_byte(CHAR_P);
		push_byte(CHAR_DOT);
		temp_hint = 1234;
		band_hint = 200;
		// random part, mostly well-formed commands and ticks near the band edges
		while (pending_reqs.size() < TOTAL_REQS) begin
			sel = $urandom_range(0, 99);
			if (sel < 12) begin
				case ($urandom_range(0, 6))
					0: value = 2;
					1: value = 0;
					2: value = 202;
					3: value = 200;
					4: value = 9999;
					default: value = $urandom_range(0, 220);
				endcase
				nd = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : NUM_DIGITS;
				push_byte(CHAR_H);
				push_number(value, nd);
				push_byte(CHAR_DOT);
				if (nd == NUM_DIGITS)
					band_hint = value;
			end else if (sel < 24) begin
				value = ($urandom_range(0, 9) == 0) ? 9999 : $urandom_range(0, 1100);
				push_byte(CHAR_T);
				push_number(value, NUM_DIGITS);
				push_byte(CHAR_DOT);
				temp_hint = value;
			end else if (sel < 34) begin
				push_byte((sel < 30) ? CHAR_S : CHAR_R);
				case ($urandom_range(0, 5))
					0: push_byte(CHAR_ZERO);
					1: push_byte(8'($urandom));
					default: push_byte(CHAR_ONE);
				endcase
				push_byte(CHAR_DOT);
			end else if (sel < 37) begin
				push_byte(CHAR_P);
				push_number($urandom_range(0, 9999), $urandom_range(0, 5));
				push_byte(CHAR_DOT);
			end else if (sel < 80) begin
				if ($urandom_range(0, 4) == 0) begin
					sp = $urandom_range(0, 1023);
				end else begin
					case ($urandom_range(0, 4))
						0: off = -band_hint + $urandom_range(0, 2) - 1;
						1: off = band_hint + $urandom_range(0, 2) - 1;
						2: off = $urandom_range(0, 2) - 1;
						default: off = $urandom_range(0, 2 * band_hint + 10) - band_hint - 5;
					endcase
					sp = temp_hint + off;
					if (sp < 0)
						sp = 0;
					if (sp > 1023)
						sp = 1023;
				end
				push_tick(sp, $urandom_range(0, 9) == 0, $urandom_range(0, 3) == 0,
						$urandom_range(0, 3) == 0);
			end else if (sel < 90) begin
				push_byte(8'($urandom_range(0, 255)));
			end else if (sel < 95) begin
				push_byte(pick_letter());
				repeat ($urandom_range(0, 3))
					push_byte(8'($urandom_range(0, 255)));
			end else begin
				push_byte(CHAR_DOT);
			end
		end
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin
		thermo_req_t r;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= 1'b0;
			send_gap <= 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if ($urandom_range(0, 39) == 0)
				send_calm <= ~send_calm;
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				s_axis_tvalid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				r = pending_reqs.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {3'b000, r.dn_b, r.up_b, r.run_b, r.sp, r.rx};
				s_axis_tuser <= r.tick;
				if (!send_calm && pending_reqs.size() >= TAIL_REQS &&
						$urandom_range(0, 4) == 0)
					send_gap <= $urandom_range(1, 15);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// result receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_gap <= 0;
		end else if (hold_left != 0) begin
			m_axis_tready <= 1'b0;
		end else if (recv_gap != 0) begin
			recv_gap <= recv_gap - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if ($urandom_range(0, 39) == 0)
				recv_calm <= ~recv_calm;
			if (!recv_calm && pending_reqs.size() >= TAIL_REQS && $urandom_range(0, 5) == 0)
				recv_gap <= $urandom_range(1, 15);
		end
	end

	// one long hold-off so the input side backs up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && results_checked >= HOLD_AFTER) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// prediction on accepted requests, checking on accepted results
	always @(posedge clk or negedge arst_n) begin
		thermo_req_t r;
		thermo_result_t want;
		thermo_result_t got;
		if (!arst_n) begin
			clear_thermostat();
			expected_results.delete();
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				r.tick = s_axis_tuser;
				r.rx = s_axis_tdata[7:0];
				r.sp = s_axis_tdata[17:8];
				r.run_b = s_axis_tdata[18];
				r.up_b = s_axis_tdata[19];
				r.dn_b = s_axis_tdata[20];
				expected_results.push_back(thermostat_next(r));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				results_checked <= results_checked + 1;
				if (expected_results.size() == 0) begin
					report_mismatch("result with nothing pending", m_axis_tdata, -1);
				end else begin
					want = expected_results.pop_front();
					got.heater = m_axis_tdata[0];
					got.fan = m_axis_tdata[1];
					got.running = m_axis_tdata[2];
					got.band = m_axis_tdata[18:3];
					got.heater_rep = m_axis_tdata[19];
					got.run_rep = m_axis_tdata[20];
					got.band_rep = m_axis_tdata[21];
					check_field("heater_on", got.heater, want.heater);
					check_field("fan_on", got.fan, want.fan);
					check_field("running", got.running, want.running);
					check_field("band_now", got.band, want.band);
					check_field("heater_report", got.heater_rep, want.heater_rep);
					check_field("run_report", got.run_rep, want.run_rep);
					check_field("band_report", got.band_rep, want.band_rep);
				end
			end
		end
	end

	initial begin
		@(posedge arst_n);
		@(posedge clk);
		while (pending_reqs.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d requests: %0d ticks, %0d serial bytes, %0d commands closed",
				ticks_seen + bytes_seen, ticks_seen, bytes_seen, commands_closed);
		$display("band clamped %0d times at the top and %0d at the bottom, %0d results checked",
				band_top_hits, band_bottom_hits, results_checked);
		if (errors == 0) begin
			$display("serial_commanded_hysteresis_thermostat_top: match");
		end else begin
			$display("serial_commanded_hysteresis_thermostat_top: mismatch");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("timed out with %0d results outstanding", expected_results.size());
		$display("serial_commanded_hysteresis_thermostat_top: mismatch");
		$finish;
	end

endmodule

### sim.f
+incdir+hdl
hdl/scht_pkg.sv
hdl/scht_front.sv
hdl/scht_queue.sv
hdl/scht_back.sv
hdl/serial_commanded_hysteresis_thermostat_top.sv
bench/tb_top.sv
